// ===== sv/ppt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppt_pkg: shared types and constants for the pointer packet tracker
// Beat layouts, register indexes, widths and the config-time helpers that
// turn register writes into the values the datapath uses.
// ---------------------------------------------------------------------------
package ppt_pkg;

    // coordinate and wheel accumulator widths
    localparam int COORD_BITS = 12;
    localparam int WHEEL_BITS = 16;

    // fixed widths of the device byte and the register port
    localparam int BYTE_W     = 8;
    localparam int BUTTON_W   = 3;
    localparam int SCALE_W    = 6;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // packet framing
    localparam int SYNC_BIT_POS = 3;
    localparam int IDX_W        = 2;

    // gain limits and divide-by-ten reciprocal (exact for magnitudes below 16384)
    localparam int SCALE_MIN   = 5;
    localparam int SCALE_MAX   = 40;
    localparam int SCALE_RESET = 10;
    localparam int RECIP_10    = 6554;
    localparam int RECIP_SHIFT = 16;
    localparam int FACTOR_W    = $clog2(SCALE_MAX * RECIP_10 + 1);

    // scaled step: |delta| <= 128, gain <= 40 tenths
    localparam int STEP_MAX = (128 * SCALE_MAX) / 10;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);
    localparam int PROD_W   = BYTE_W + FACTOR_W;
    localparam int SUM_W    = ((COORD_BITS > STEP_W) ? COORD_BITS : STEP_W) + 2;

    // screen size handling
    localparam int MAX_SIZE = 1 << COORD_BITS;
    localparam int LIM_W    = (SIZE_W > COORD_BITS + 1) ? SIZE_W : COORD_BITS + 1;

    // reset values
    localparam int CURSOR_X_RESET = 512;
    localparam int CURSOR_Y_RESET = 384;
    localparam int WIDTH_RESET    = 1024;
    localparam int HEIGHT_RESET   = 768;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TENTHS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(3);

    // operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [FACTOR_W-1:0]   factor_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic                         packet_done;
        logic                         byte_dropped;
        coord_t                       pos_x;
        coord_t                       pos_y;
        logic [BUTTON_W-1:0]          buttons;
        logic signed [WHEEL_BITS-1:0] wheel_delta;
    } result_t;

    // per-axis settings handed to the axis update
    typedef struct packed {
        factor_t gain;
        coord_t  coord_max;
    } axis_cfg_t;

    // clamp the gain and fold in the divide-by-ten reciprocal
    function automatic factor_t scale_to_factor(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] c;
        begin
            c = s;
            if (s < SCALE_W'(SCALE_MIN))
            begin
                c = SCALE_W'(SCALE_MIN);
            end
            else if (s > SCALE_W'(SCALE_MAX))
            begin
                c = SCALE_W'(SCALE_MAX);
            end
            return FACTOR_W'(c) * FACTOR_W'(RECIP_10);
        end
    endfunction

    // largest legal coordinate for a screen size
    function automatic coord_t size_to_max(input logic [SIZE_W-1:0] s);
        logic [LIM_W-1:0] w;
        begin
            w = LIM_W'(s);
            if (w == '0)
            begin
                return '0;
            end
            else if (w > LIM_W'(MAX_SIZE))
            begin
                return '1;
            end
            return COORD_BITS'(w - LIM_W'(1));
        end
    endfunction

endpackage

// ===== sv/ppt_axis.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppt_axis: one cursor axis update
// Scales a signed delta byte by the gain (truncating toward zero), moves
// the coordinate up or down by it and clamps to the screen.
// ---------------------------------------------------------------------------
module ppt_axis
(
    input  ppt_pkg::coord_t            coord,
    input  logic [ppt_pkg::BYTE_W-1:0] delta,
    input  logic                       subtract,
    input  ppt_pkg::axis_cfg_t         cfg,
    output ppt_pkg::coord_t            coord_next
);

    logic                              neg;
    logic [ppt_pkg::BYTE_W-1:0]        mag;
    logic [ppt_pkg::PROD_W-1:0]        prod;
    logic [ppt_pkg::STEP_W-1:0]        step;
    logic                              move_down;
    logic signed [ppt_pkg::SUM_W-1:0]  base;
    logic signed [ppt_pkg::SUM_W-1:0]  offs;
    logic signed [ppt_pkg::SUM_W-1:0]  sum;
    logic signed [ppt_pkg::SUM_W-1:0]  limit;

    // magnitude of the delta byte, then gain times reciprocal of ten
    assign neg  = delta[ppt_pkg::BYTE_W-1];
    assign mag  = neg ? (~delta + ppt_pkg::BYTE_W'(1)) : delta;
    assign prod = ppt_pkg::PROD_W'(mag) * ppt_pkg::PROD_W'(cfg.gain);
    assign step = prod[ppt_pkg::RECIP_SHIFT +: ppt_pkg::STEP_W];

    // direction of motion on this axis
    assign move_down = neg ^ subtract;
    assign base      = $signed(ppt_pkg::SUM_W'(coord));
    assign offs      = $signed(ppt_pkg::SUM_W'(step));
    assign sum       = move_down ? (base - offs) : (base + offs);
    assign limit     = $signed(ppt_pkg::SUM_W'(cfg.coord_max));

    // clamp to the screen
    always_comb
    begin
        priority if (sum < 0)
        begin
            coord_next = '0;
        end
        else if (sum > limit)
        begin
            coord_next = cfg.coord_max;
        end
        else
        begin
            coord_next = ppt_pkg::COORD_BITS'(sum);
        end
    end

endmodule

// ===== sv/pointer_packet_tracker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pointer_packet_tracker: pointer device packet framer and cursor tracker
// Frames device bytes into 3- or 4-byte packets, resyncs on the sync bit,
// scales and clamps cursor motion and keeps a saturating wheel accumulator.
// ---------------------------------------------------------------------------
// Path: an accepted beat sits in the input register and moves on to the
//   result register once that register is free or draining.
// Throughput: one beat per cycle unless result_stall holds; the framing
//   and cursor state loop closes through the gain multiplier, adder, clamp.
// Reset: both stages empty, cursor at 512,384, framing and wheel cleared,
//   registers at 3-byte mode, gain 10 tenths, screen 1024 x 768.
module pointer_packet_tracker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  ppt_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output ppt_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int W = ppt_pkg::WHEEL_BITS;

    // configuration
    logic                     wheel_mode_reg;
    ppt_pkg::factor_t         gain_reg;
    ppt_pkg::coord_t          x_max_reg;
    ppt_pkg::coord_t          y_max_reg;

    // pipeline registers
    logic                     item_valid_reg;
    ppt_pkg::item_t           item_reg;
    logic                     result_valid_reg;
    ppt_pkg::result_t         result_reg;
    ppt_pkg::result_t         result_next;

    // tracker state
    logic [ppt_pkg::IDX_W-1:0]    byte_index_reg;
    logic [ppt_pkg::IDX_W-1:0]    byte_index_next;
    logic [ppt_pkg::BUTTON_W-1:0] first_byte_reg;
    logic [ppt_pkg::BUTTON_W-1:0] first_byte_next;
    logic [ppt_pkg::BYTE_W-1:0]   delta_x_reg;
    logic [ppt_pkg::BYTE_W-1:0]   delta_x_next;
    logic [ppt_pkg::BYTE_W-1:0]   delta_y_reg;
    logic [ppt_pkg::BYTE_W-1:0]   delta_y_next;
    ppt_pkg::coord_t              cursor_x_reg;
    ppt_pkg::coord_t              cursor_x_next;
    ppt_pkg::coord_t              cursor_y_reg;
    ppt_pkg::coord_t              cursor_y_next;
    logic signed [W-1:0]          wheel_sum_reg;
    logic signed [W-1:0]          wheel_sum_next;

    // datapath
    logic                     fire;
    logic                     is_byte;
    logic                     drop;
    logic                     take;
    logic                     complete;
    logic [ppt_pkg::BYTE_W-1:0] data;
    logic [ppt_pkg::BYTE_W-1:0] y_byte;
    logic signed [W:0]        wheel_add;
    logic signed [W-1:0]      wheel_sat;
    ppt_pkg::coord_t          x_moved;
    ppt_pkg::coord_t          y_moved;
    ppt_pkg::axis_cfg_t       x_cfg;
    ppt_pkg::axis_cfg_t       y_cfg;

    // handshake: the stage moves when the result register is free or draining
    assign fire         = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = item_valid_reg && !fire;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg <= 1'b0;
            gain_reg       <= ppt_pkg::scale_to_factor(ppt_pkg::SCALE_W'(ppt_pkg::SCALE_RESET));
            x_max_reg      <= ppt_pkg::size_to_max(ppt_pkg::SIZE_W'(ppt_pkg::WIDTH_RESET));
            y_max_reg      <= ppt_pkg::size_to_max(ppt_pkg::SIZE_W'(ppt_pkg::HEIGHT_RESET));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppt_pkg::CFG_WHEEL_MODE:
                begin
                    wheel_mode_reg <= cfg_wdata[0];
                end
                ppt_pkg::CFG_SCALE_TENTHS:
                begin
                    gain_reg <= ppt_pkg::scale_to_factor(cfg_wdata[ppt_pkg::SCALE_W-1:0]);
                end
                ppt_pkg::CFG_SCREEN_WIDTH:
                begin
                    x_max_reg <= ppt_pkg::size_to_max(cfg_wdata[ppt_pkg::SIZE_W-1:0]);
                end
                ppt_pkg::CFG_SCREEN_HEIGHT:
                begin
                    y_max_reg <= ppt_pkg::size_to_max(cfg_wdata[ppt_pkg::SIZE_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // framing decisions for the beat in the input register
    assign data     = item_reg.data_byte;
    assign is_byte  = (item_reg.op == ppt_pkg::OP_BYTE);
    assign drop     = is_byte && (byte_index_reg == '0) && !data[ppt_pkg::SYNC_BIT_POS];
    assign take     = is_byte && !drop;
    assign complete = take && (wheel_mode_reg ? (byte_index_reg == 2'd3)
                                              : (byte_index_reg >= 2'd2));

    // the third byte may arrive with this beat
    assign y_byte = (byte_index_reg == 2'd2) ? data : delta_y_reg;

    assign x_cfg = '{gain: gain_reg, coord_max: x_max_reg};
    assign y_cfg = '{gain: gain_reg, coord_max: y_max_reg};

    ppt_axis u_axis_x
    (
        .coord      (cursor_x_reg),
        .delta      (delta_x_reg),
        .subtract   (1'b0),
        .cfg        (x_cfg),
        .coord_next (x_moved)
    );

    ppt_axis u_axis_y
    (
        .coord      (cursor_y_reg),
        .delta      (y_byte),
        .subtract   (1'b1),
        .cfg        (y_cfg),
        .coord_next (y_moved)
    );

    // saturating wheel add of the signed fourth byte
    assign wheel_add = {wheel_sum_reg[W-1], wheel_sum_reg}
                     + {{(W + 1 - ppt_pkg::BYTE_W){data[ppt_pkg::BYTE_W-1]}}, data};

    always_comb
    begin
        if (wheel_add[W] != wheel_add[W-1])
        begin
            wheel_sat = wheel_add[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        end
        else
        begin
            wheel_sat = wheel_add[W-1:0];
        end
    end

    // next state and result beat
    always_comb
    begin
        byte_index_next = byte_index_reg;
        first_byte_next = first_byte_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        wheel_sum_next  = wheel_sum_reg;

        if (take)
        begin
            unique case (byte_index_reg)
                2'd0:
                begin
                    first_byte_next = data[ppt_pkg::BUTTON_W-1:0];
                end
                2'd1:
                begin
                    delta_x_next = data;
                end
                2'd2:
                begin
                    delta_y_next = data;
                end
                default:
                begin
                end
            endcase
            byte_index_next = complete ? '0 : byte_index_reg + 2'd1;
        end

        if (complete)
        begin
            cursor_x_next = x_moved;
            cursor_y_next = y_moved;
            if (wheel_mode_reg)
            begin
                wheel_sum_next = wheel_sat;
            end
        end

        if (!is_byte)
        begin
            wheel_sum_next = '0;
        end

        result_next.packet_done  = complete;
        result_next.byte_dropped = drop;
        result_next.pos_x        = cursor_x_next;
        result_next.pos_y        = cursor_y_next;
        result_next.buttons      = first_byte_next;
        result_next.wheel_delta  = is_byte ? '0 : wheel_sum_reg;
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            first_byte_reg   <= '0;
            delta_x_reg      <= '0;
            delta_y_reg      <= '0;
            cursor_x_reg     <= ppt_pkg::COORD_BITS'(ppt_pkg::CURSOR_X_RESET);
            cursor_y_reg     <= ppt_pkg::COORD_BITS'(ppt_pkg::CURSOR_Y_RESET);
            wheel_sum_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            byte_index_reg   <= byte_index_next;
            first_byte_reg   <= first_byte_next;
            delta_x_reg      <= delta_x_next;
            delta_y_reg      <= delta_y_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            wheel_sum_reg    <= wheel_sum_next;
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    // checks
    a_done_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.packet_done && result_reg.byte_dropped))
        else $error("packet done and byte dropped in one beat");

    a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item_reg.op == ppt_pkg::OP_CONSUME) |=> (wheel_sum_reg == '0))
        else $error("wheel accumulator not cleared after consume");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && complete |=> (byte_index_reg == '0))
        else $error("framing did not restart after a packet");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (item_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled without a blocked result");

    a_x_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.packet_done |-> (result_reg.pos_x <= x_max_reg))
        else $error("cursor x beyond screen after packet");

endmodule
